### design/i2c_tar_pkg.sv
// Shared types and constants of the I2C target address recognizer.
// No dependencies.
`timescale 1ns / 1ps

package i2c_tar_pkg;

  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_START = 3'd1,
    EV_STOP  = 3'd2,
    EV_RISE  = 3'd3,
    EV_FALL  = 3'd4,
    EV_DATA  = 3'd5
  } bus_event_t;

  localparam int unsigned ADDR_W = 7;
  localparam int unsigned MASK_W = 8;
  localparam logic [MASK_W-1:0] FIRST_BIT = 8'h80;
  localparam logic [MASK_W-1:0] DIR_BIT   = 8'h01;

  // Line select codes
  localparam logic LINE_SDA = 1'b0;
  localparam logic LINE_SCL = 1'b1;

  // Register indexes
  localparam logic REG_OWN_ADDRESS   = 1'b0;
  localparam logic REG_TARGET_ENABLE = 1'b1;

  // Write of the enable register: both state machines re-sync on it
  typedef struct packed {
    logic en_wr;
    logic en_val;
  } cfg_ctl_t;

endpackage

### design/i2c_tar_observer.sv
// Bus observer: keeps SDA/SCL levels and turns one line edge into a bus event.
// Depends on i2c_tar_pkg.
`timescale 1ns / 1ps

module i2c_tar_observer (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic                   line_select,
  input  logic                   new_level,
  input  logic                   enable,
  input  i2c_tar_pkg::cfg_ctl_t  cfg_ctl,
  output i2c_tar_pkg::bus_event_t bus_event,
  output logic                   sda_level
);

  typedef enum logic [2:0] {
    OBS_DHCH = 3'd0,
    OBS_DHCL = 3'd1,
    OBS_DLCH = 3'd2,
    OBS_DLCL = 3'd3,
    OBS_WAIT = 3'd4
  } obs_phase_t;

  obs_phase_t phase_r, phase_nxt;
  logic       sda_r, scl_r;
  logic       sda_nxt, scl_nxt;
  logic       is_clk;

  assign is_clk    = (line_select == i2c_tar_pkg::LINE_SCL);
  assign sda_nxt   = is_clk ? sda_r : new_level;
  assign scl_nxt   = is_clk ? new_level : scl_r;
  assign sda_level = sda_nxt;

  always_comb begin
    phase_nxt = phase_r;
    bus_event = i2c_tar_pkg::EV_NONE;
    case (phase_r)
      OBS_DHCH: begin
        if (!new_level) begin
          if (is_clk) begin
            phase_nxt = OBS_DHCL;
            bus_event = i2c_tar_pkg::EV_FALL;
          end else begin
            phase_nxt = OBS_DLCH;
            bus_event = i2c_tar_pkg::EV_START;
          end
        end
      end
      OBS_DHCL: begin
        if (is_clk) begin
          if (new_level) begin
            phase_nxt = OBS_DHCH;
            bus_event = i2c_tar_pkg::EV_RISE;
          end
        end else if (!new_level) begin
          phase_nxt = OBS_DLCL;
          bus_event = i2c_tar_pkg::EV_DATA;
        end
      end
      OBS_DLCH: begin
        if (is_clk) begin
          if (!new_level) begin
            phase_nxt = OBS_DLCL;
            bus_event = i2c_tar_pkg::EV_FALL;
          end
        end else if (new_level) begin
          phase_nxt = OBS_DHCH;
          bus_event = i2c_tar_pkg::EV_STOP;
        end
      end
      OBS_DLCL: begin
        if (is_clk) begin
          if (new_level) begin
            phase_nxt = OBS_DLCH;
            bus_event = i2c_tar_pkg::EV_RISE;
          end
        end else if (new_level) begin
          phase_nxt = OBS_DHCL;
          bus_event = i2c_tar_pkg::EV_DATA;
        end
      end
      default: begin
        // waiting: sync once both lines read high, no event
        phase_nxt = (sda_nxt && scl_nxt) ? OBS_DHCH : OBS_WAIT;
      end
    endcase
    if (!enable) begin
      phase_nxt = phase_r;
      bus_event = i2c_tar_pkg::EV_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= OBS_WAIT;
      sda_r   <= 1'b1;
      scl_r   <= 1'b1;
    end else if (cfg_ctl.en_wr) begin
      phase_r <= (cfg_ctl.en_val && sda_r && scl_r) ? OBS_DHCH : OBS_WAIT;
    end else if (step) begin
      phase_r <= phase_nxt;
      sda_r   <= sda_nxt;
      scl_r   <= scl_nxt;
    end
  end

endmodule

### design/i2c_tar_receiver.sv
// Address receiver: walks a one-hot bit mask over the address byte, compares
// seven bits with the own address and samples the direction bit. Uses i2c_tar_pkg.
`timescale 1ns / 1ps

module i2c_tar_receiver (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step,
  input  logic                                enable,
  input  i2c_tar_pkg::cfg_ctl_t               cfg_ctl,
  input  logic [i2c_tar_pkg::ADDR_W-1:0]      own_address,
  input  i2c_tar_pkg::bus_event_t             bus_event,
  input  logic                                sda_level,
  output logic                                address_matched,
  output logic                                read_request,
  output logic                                address_mismatch
);

  typedef enum logic [1:0] {
    RX_IDLE = 2'd0,
    RX_FALL = 2'd1,
    RX_RISE = 2'd2,
    RX_DONE = 2'd3
  } rx_phase_t;

  rx_phase_t                        phase_r, phase_nxt;
  logic [i2c_tar_pkg::MASK_W-1:0]   mask_r, mask_nxt;
  logic                             want;

  assign want = |({own_address, 1'b0} & mask_r);

  always_comb begin
    phase_nxt        = phase_r;
    mask_nxt         = mask_r;
    address_matched  = 1'b0;
    read_request     = 1'b0;
    address_mismatch = 1'b0;
    if (enable) begin
      if (bus_event == i2c_tar_pkg::EV_START) begin
        phase_nxt = RX_FALL;
        mask_nxt  = '0;
      end else if (bus_event == i2c_tar_pkg::EV_STOP) begin
        phase_nxt = RX_IDLE;
      end else if (phase_r == RX_FALL && bus_event == i2c_tar_pkg::EV_FALL) begin
        mask_nxt  = (mask_r != '0) ? (mask_r >> 1) : i2c_tar_pkg::FIRST_BIT;
        phase_nxt = RX_RISE;
      end else if (phase_r == RX_RISE && bus_event == i2c_tar_pkg::EV_RISE) begin
        if (mask_r == i2c_tar_pkg::DIR_BIT) begin
          address_matched = 1'b1;
          read_request    = sda_level;
          phase_nxt       = RX_DONE;
        end else if (want == sda_level) begin
          phase_nxt = RX_FALL;
        end else begin
          address_mismatch = 1'b1;
          phase_nxt        = RX_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= RX_IDLE;
      mask_r  <= '0;
    end else if (cfg_ctl.en_wr) begin
      phase_r <= RX_IDLE;
      mask_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      mask_r  <= mask_nxt;
    end
  end

endmodule

### design/i2c_target_address_recognizer_unit.sv
// I2C target address recognizer, 7-bit addressing. Uses i2c_tar_pkg,
// i2c_tar_observer and i2c_tar_receiver.
// Result beat is registered in one result register, in the cycle after the input beat is taken.
// Throughput: one beat per cycle; input is taken while the result register is
// empty or being drained in the same cycle.
// Reset (rst_n low, synchronous): config registers 0, lines high, observer waiting.
`timescale 1ns / 1ps

module i2c_target_address_recognizer_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [0] new_level, [7:1] zero
  input  logic       in_tuser,   // [0] line_select
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [2:0] bus_event, [3] address_matched,
                                 // [4] read_request, [5] address_mismatch, [7:6] zero
  input  logic       cfg_wr_en,
  input  logic       cfg_addr,
  input  logic [6:0] cfg_wdata
);

  logic [i2c_tar_pkg::ADDR_W-1:0] own_address_r;
  logic                           enable_r;
  i2c_tar_pkg::cfg_ctl_t          cfg_ctl;
  i2c_tar_pkg::bus_event_t        bus_event;
  logic                           step, sda_level;
  logic                           matched, rd, miss;
  logic                           out_valid_r;
  logic [7:0]                     out_data_r;

  assign in_tready = !out_valid_r || out_tready;
  assign step      = in_tvalid && in_tready;
  assign cfg_ctl   = '{en_wr:  cfg_wr_en && (cfg_addr == i2c_tar_pkg::REG_TARGET_ENABLE),
                       en_val: cfg_wdata[0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_address_r <= '0;
      enable_r      <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        i2c_tar_pkg::REG_OWN_ADDRESS:   own_address_r <= cfg_wdata;
        i2c_tar_pkg::REG_TARGET_ENABLE: enable_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  i2c_tar_observer u_observer (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .line_select (in_tuser),
    .new_level   (in_tdata[0]),
    .enable      (enable_r),
    .cfg_ctl     (cfg_ctl),
    .bus_event   (bus_event),
    .sda_level   (sda_level)
  );

  i2c_tar_receiver u_receiver (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (step),
    .enable           (enable_r),
    .cfg_ctl          (cfg_ctl),
    .own_address      (own_address_r),
    .bus_event        (bus_event),
    .sda_level        (sda_level),
    .address_matched  (matched),
    .read_request     (rd),
    .address_mismatch (miss)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= {2'b00, miss, rd, matched, bus_event};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### tb/tb_i2c_target_address_recognizer_unit.sv
// Self-checking bench for the I2C target address recognizer: directed rows, then random
// address frames and line noise, each result checked against an in-bench line/address model.
// Depends on i2c_tar_pkg and i2c_target_address_recognizer_unit.
`timescale 1ns / 1ps

module tb_i2c_target_address_recognizer_unit;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned EDGE_TARGET = 1100;
  localparam int unsigned N_DIR = 32;

  // line phase: first letter SDA, second SCL
  typedef enum logic [2:0] {LN_HH, LN_HL, LN_LH, LN_LL, LN_WAIT} line_phase_t;
  typedef enum logic [1:0] {ADDR_IDLE, ADDR_WAIT_FALL, ADDR_WAIT_RISE, ADDR_DONE} addr_phase_t;
  typedef enum logic {ROW_REG, ROW_EDGE} row_kind_t;

  typedef struct packed {
    logic                    miss;
    logic                    rd;
    logic                    matched;
    i2c_tar_pkg::bus_event_t ev;
  } addr_result_t;

  typedef struct packed {
    row_kind_t    kind;
    logic         sel_idx;  // line select, or register index
    logic [6:0]   val;      // level in bit 0, or register value
    bit           fixed;
    addr_result_t res;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tuser = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_addr = 1'b0;
  logic [6:0] cfg_wdata = 7'h00;

  // model state
  logic [6:0]  own_addr = '0;
  logic        tgt_en = 1'b0;
  line_phase_t line_st = LN_WAIT;
  logic        sda_lvl = 1'b1;
  logic        scl_lvl = 1'b1;
  addr_phase_t addr_st = ADDR_IDLE;
  logic [7:0]  bit_sel = '0;

  addr_result_t pending_results[$];
  dir_row_t     dir_rows [N_DIR];
  int unsigned  fail_cnt = 0;
  int unsigned  cycle_cnt = 0;
  int unsigned  edges_sent = 0;
  bit           src_free = 1'b0;
  bit           sink_free = 1'b0;
  int unsigned  sink_mode_left = 0;
  int unsigned  stall_left = 0;

  i2c_target_address_recognizer_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [0] new_level
    .in_tuser   (in_tuser),   // [0] line_select
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [2:0] bus_event, [3] matched, [4] read_request, [5] mismatch
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // mostly short idles, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic addr_result_t predict_edge(logic sel, logic lev);
    addr_result_t            r;
    i2c_tar_pkg::bus_event_t ev;
    logic                    want;
    r = '{miss: 1'b0, rd: 1'b0, matched: 1'b0, ev: i2c_tar_pkg::EV_NONE};
    ev = i2c_tar_pkg::EV_NONE;
    if (sel == i2c_tar_pkg::LINE_SCL) scl_lvl = lev;
    else sda_lvl = lev;
    if (!tgt_en) return r;
    case (line_st)
      LN_HH: begin
        if (!lev) begin
          if (sel == i2c_tar_pkg::LINE_SCL) begin
            line_st = LN_HL; ev = i2c_tar_pkg::EV_FALL;
          end else begin
            line_st = LN_LH; ev = i2c_tar_pkg::EV_START;
          end
        end
      end
      LN_HL: begin
        if (sel == i2c_tar_pkg::LINE_SCL) begin
          if (lev) begin line_st = LN_HH; ev = i2c_tar_pkg::EV_RISE; end
        end else if (!lev) begin
          line_st = LN_LL; ev = i2c_tar_pkg::EV_DATA;
        end
      end
      LN_LH: begin
        if (sel == i2c_tar_pkg::LINE_SCL) begin
          if (!lev) begin line_st = LN_LL; ev = i2c_tar_pkg::EV_FALL; end
        end else if (lev) begin
          line_st = LN_HH; ev = i2c_tar_pkg::EV_STOP;
        end
      end
      LN_LL: begin
        if (sel == i2c_tar_pkg::LINE_SCL) begin
          if (lev) begin line_st = LN_LH; ev = i2c_tar_pkg::EV_RISE; end
        end else if (lev) begin
          line_st = LN_HL; ev = i2c_tar_pkg::EV_DATA;
        end
      end
      default: begin
        // resync silently once both lines are seen high
        line_st = (sda_lvl && scl_lvl) ? LN_HH : LN_WAIT;
      end
    endcase

    if (ev == i2c_tar_pkg::EV_START) begin
      addr_st = ADDR_WAIT_FALL;
      bit_sel = '0;
    end else if (ev == i2c_tar_pkg::EV_STOP) begin
      addr_st = ADDR_IDLE;
    end else if (addr_st == ADDR_WAIT_FALL && ev == i2c_tar_pkg::EV_FALL) begin
      bit_sel = (bit_sel != '0) ? (bit_sel >> 1) : i2c_tar_pkg::FIRST_BIT;
      addr_st = ADDR_WAIT_RISE;
    end else if (addr_st == ADDR_WAIT_RISE && ev == i2c_tar_pkg::EV_RISE) begin
      if (bit_sel == i2c_tar_pkg::DIR_BIT) begin
        r.matched = 1'b1;
        r.rd = sda_lvl;
        addr_st = ADDR_DONE;
      end else begin
        want = |({own_addr, 1'b0} & bit_sel);
        if (want == sda_lvl) begin
          addr_st = ADDR_WAIT_FALL;
        end else begin
          r.miss = 1'b1;
          addr_st = ADDR_IDLE;
        end
      end
    end
    r.ev = ev;
    return r;
  endfunction

  function automatic dir_row_t reg_row(logic idx, logic [6:0] val);
    return '{kind: ROW_REG, sel_idx: idx, val: val, fixed: 1'b0, res: '0};
  endfunction

  function automatic dir_row_t beat_row(logic sel, logic lev);
    return '{kind: ROW_EDGE, sel_idx: sel, val: {6'b0, lev}, fixed: 1'b0, res: '0};
  endfunction

  function automatic dir_row_t beat_chk(logic sel, logic lev, i2c_tar_pkg::bus_event_t ev,
                                        logic miss);
    return '{kind: ROW_EDGE, sel_idx: sel, val: {6'b0, lev}, fixed: 1'b1,
             res: '{miss: miss, rd: 1'b0, matched: 1'b0, ev: ev}};
  endfunction

  task automatic send_edge(input logic sel, input logic lev, input bit use_fixed = 1'b0,
                           input addr_result_t fixed_res = '0);
    addr_result_t r;
    int unsigned  gap;
    in_tvalid <= 1'b1;
    in_tuser  <= sel;
    in_tdata  <= {7'b0, lev};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    edges_sent++;
    r = predict_edge(sel, lev);
    pending_results.push_back(use_fixed ? fixed_res : r);
    gap = (src_free || $urandom_range(0, 9) < 6) ? 0 : idle_len();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait until every result is in, plus the result register's latency
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [6:0] val);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == i2c_tar_pkg::REG_OWN_ADDRESS) begin
      own_addr = val;
    end else begin
      tgt_en = val[0];
      addr_st = ADDR_IDLE;
      bit_sel = '0;
      line_st = (tgt_en && sda_lvl && scl_lvl) ? LN_HH : LN_WAIT;
    end
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_bit(logic b);
    send_edge(i2c_tar_pkg::LINE_SCL, 1'b0);
    if (sda_lvl != b) send_edge(i2c_tar_pkg::LINE_SDA, b);
    if ($urandom_range(0, 99) < 4) begin
      send_edge(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
    send_edge(i2c_tar_pkg::LINE_SCL, 1'b1);
  endtask

  task automatic send_noise(int unsigned n);
    repeat (n) send_edge(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_frame();
    logic [6:0]  addr;
    logic        dir;
    int unsigned nbits;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) addr = own_addr;
    else if (r < 70) addr = own_addr ^ (7'h01 << $urandom_range(0, 6));
    else addr = 7'($urandom_range(0, 127));
    dir = 1'($urandom_range(0, 1));
    // bring both lines high, then start
    if (!sda_lvl) begin
      if (scl_lvl) send_edge(i2c_tar_pkg::LINE_SCL, 1'b0);
      send_edge(i2c_tar_pkg::LINE_SDA, 1'b1);
    end
    if (!scl_lvl) send_edge(i2c_tar_pkg::LINE_SCL, 1'b1);
    send_edge(i2c_tar_pkg::LINE_SDA, 1'b0);
    nbits = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 7) : 8;
    for (int unsigned i = 0; i < nbits; i++) begin
      send_bit((i < 7) ? addr[6-i] : dir);
    end
    repeat ($urandom_range(0, 9)) send_bit(1'($urandom_range(0, 1)));
    r = $urandom_range(0, 99);
    if (r < 55) begin
      send_edge(i2c_tar_pkg::LINE_SCL, 1'b0);
      if (sda_lvl) send_edge(i2c_tar_pkg::LINE_SDA, 1'b0);
      send_edge(i2c_tar_pkg::LINE_SCL, 1'b1);
      send_edge(i2c_tar_pkg::LINE_SDA, 1'b1);
    end else if (r >= 85) begin
      send_noise($urandom_range(1, 5));
    end
  endtask

  // result side: random stalls, with stall-free stretches
  always @(posedge clk) begin
    if (sink_mode_left == 0) begin
      sink_free = ($urandom_range(0, 9) < 3);
      sink_mode_left = $urandom_range(50, 300);
    end else begin
      sink_mode_left--;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!sink_free && $urandom_range(0, 3) == 0) begin
      stall_left = idle_len() - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    addr_result_t got;
    addr_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      got = addr_result_t'(out_tdata[5:0]);
      if (pending_results.size() == 0) begin
        if (fail_cnt < 10) $display("unexpected result beat: tdata=%h", out_tdata);
        fail_cnt++;
      end else begin
        exp_res = pending_results.pop_front();
        if (got.ev !== exp_res.ev || got.matched !== exp_res.matched ||
            got.rd !== exp_res.rd || got.miss !== exp_res.miss) begin
          if (fail_cnt < 10) begin
            $display("mismatch: exp ev=%0d match=%b rd=%b miss=%b,",
                     exp_res.ev, exp_res.matched, exp_res.rd, exp_res.miss,
                     " got ev=%0d match=%b rd=%b miss=%b",
                     got.ev, got.matched, got.rd, got.miss);
          end
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [6:0] a;
    int unsigned r;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    dir_rows = '{
      beat_chk(i2c_tar_pkg::LINE_SDA, 1'b0, i2c_tar_pkg::EV_NONE, 1'b0),  // disabled after reset
      beat_chk(i2c_tar_pkg::LINE_SDA, 1'b1, i2c_tar_pkg::EV_NONE, 1'b0),
      reg_row(i2c_tar_pkg::REG_OWN_ADDRESS, 7'h7F),
      reg_row(i2c_tar_pkg::REG_TARGET_ENABLE, 7'h7F),                     // upper bits ignored
      beat_chk(i2c_tar_pkg::LINE_SDA, 1'b0, i2c_tar_pkg::EV_START, 1'b0),
      beat_row(i2c_tar_pkg::LINE_SCL, 1'b0),
      beat_row(i2c_tar_pkg::LINE_SDA, 1'b1),
      beat_row(i2c_tar_pkg::LINE_SCL, 1'b1),
      beat_row(i2c_tar_pkg::LINE_SCL, 1'b0), beat_row(i2c_tar_pkg::LINE_SCL, 1'b1),
      beat_row(i2c_tar_pkg::LINE_SCL, 1'b0), beat_row(i2c_tar_pkg::LINE_SCL, 1'b1),
      beat_row(i2c_tar_pkg::LINE_SCL, 1'b0), beat_row(i2c_tar_pkg::LINE_SCL, 1'b1),
      beat_row(i2c_tar_pkg::LINE_SCL, 1'b0), beat_row(i2c_tar_pkg::LINE_SCL, 1'b1),
      beat_row(i2c_tar_pkg::LINE_SCL, 1'b0), beat_row(i2c_tar_pkg::LINE_SCL, 1'b1),
      beat_row(i2c_tar_pkg::LINE_SCL, 1'b0), beat_row(i2c_tar_pkg::LINE_SCL, 1'b1),
      beat_row(i2c_tar_pkg::LINE_SCL, 1'b0), beat_row(i2c_tar_pkg::LINE_SCL, 1'b1), // read match
      beat_chk(i2c_tar_pkg::LINE_SDA, 1'b0, i2c_tar_pkg::EV_START, 1'b0), // repeated start
      beat_row(i2c_tar_pkg::LINE_SCL, 1'b0),
      beat_chk(i2c_tar_pkg::LINE_SCL, 1'b1, i2c_tar_pkg::EV_RISE, 1'b1),  // first bit differs
      beat_chk(i2c_tar_pkg::LINE_SDA, 1'b1, i2c_tar_pkg::EV_STOP, 1'b0),
      beat_chk(i2c_tar_pkg::LINE_SDA, 1'b1, i2c_tar_pkg::EV_NONE, 1'b0),  // no level change
      reg_row(i2c_tar_pkg::REG_TARGET_ENABLE, 7'h00),
      beat_chk(i2c_tar_pkg::LINE_SCL, 1'b0, i2c_tar_pkg::EV_NONE, 1'b0),  // level kept, disabled
      reg_row(i2c_tar_pkg::REG_TARGET_ENABLE, 7'h01),                     // clock low: waits
      beat_chk(i2c_tar_pkg::LINE_SCL, 1'b1, i2c_tar_pkg::EV_NONE, 1'b0),  // silent resync
      reg_row(i2c_tar_pkg::REG_OWN_ADDRESS, 7'h00)
    };

    src_free = 1'b0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        write_reg(dir_rows[i].sel_idx, dir_rows[i].val);
      end else begin
        send_edge(dir_rows[i].sel_idx, dir_rows[i].val[0], dir_rows[i].fixed,
                  dir_rows[i].res);
      end
    end

    edges_sent = 0;
    while (edges_sent < EDGE_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 15) a = 7'h00;
      else if (r < 30) a = 7'h7F;
      else a = 7'($urandom_range(0, 127));
      write_reg(i2c_tar_pkg::REG_OWN_ADDRESS, a);
      write_reg(i2c_tar_pkg::REG_TARGET_ENABLE,
                {6'($urandom_range(0, 63)), ($urandom_range(0, 99) < 85)});
      src_free = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(3, 8)) begin
        if (edges_sent >= EDGE_TARGET) break;
        if ($urandom_range(0, 9) < 8) send_frame();
        else send_noise($urandom_range(1, 6));
      end
    end

    drain();
    if (fail_cnt == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
design/i2c_tar_pkg.sv
design/i2c_tar_observer.sv
design/i2c_tar_receiver.sv
design/i2c_target_address_recognizer_unit.sv
tb/tb_i2c_target_address_recognizer_unit.sv
